/* src/ebcalu_pkg.sv */
package ebcalu_pkg;

	// Operation codes carried in req_type
	typedef enum logic [3:0] {
		OP_ADC = 4'd0,
		OP_SBC = 4'd1,
		OP_AND = 4'd2,
		OP_ORA = 4'd3,
		OP_EOR = 4'd4,
		OP_ASL = 4'd5,
		OP_LSR = 4'd6,
		OP_ROL = 4'd7,
		OP_ROR = 4'd8,
		OP_INC = 4'd9,
		OP_DEC = 4'd10,
		OP_BIT = 4'd11
	} alu_op_t;

	// Status byte bit positions
	localparam int unsigned FLAG_C = 0;
	localparam int unsigned FLAG_Z = 1;
	localparam int unsigned FLAG_D = 3;
	localparam int unsigned FLAG_V = 6;
	localparam int unsigned FLAG_N = 7;

	// Largest valid BCD digit
	localparam logic [4:0] BCD_MAX = 5'd9;
	localparam logic [4:0] BCD_TEN = 5'd10;

	typedef struct packed {
		logic [3:0] req_type;
		logic [7:0] acc_in;
		logic [7:0] operand;
		logic [7:0] status_in;
	} alu_req_t;

	typedef struct packed {
		logic [7:0] result;
		logic [7:0] status_out;
	} alu_rsp_t;

endpackage

/* src/ebcalu_if.sv */
// Request channel: operation and operands
interface ebcalu_req_if;
	logic       valid;
	logic       ready;
	logic [3:0] req_type;
	logic [7:0] acc_in;
	logic [7:0] operand;
	logic [7:0] status_in;

	modport source (output valid, output req_type, output acc_in, output operand,
		output status_in, input ready);
	modport sink (input valid, input req_type, input acc_in, input operand,
		input status_in, output ready);
endinterface

// Response channel: result byte and new status
interface ebcalu_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] result;
	logic [7:0] status_out;

	modport source (output valid, output result, output status_out, input ready);
	modport sink (input valid, input result, input status_out, output ready);
endinterface

/* src/eight_bit_cpu_alu_with_bcd.sv */
// Eight-bit processor ALU with binary and decimal ADC/SBC.
//
// Channels: req (sink) carries req_type, acc_in, operand and status_in;
// rsp (source) carries result and status_out. Both use valid/ready and an
// item moves on a clock edge where both are high. Every request item gives
// exactly one response item, in order.
//
// The item is captured in an input register, passes the ALU logic and
// lands in the output register, which drives rsp.valid and the response.
// Throughput is one item per clock; both stages advance together, so a
// new item is taken every cycle while rsp is ready.
//
// When the receiver stalls, the output register holds its item and the
// input register still accepts one more item; req.ready then drops until
// the output drains. Reset (arst_n low) empties both stages; items held
// in them are dropped by it, and none are generated.
module eight_bit_cpu_alu_with_bcd (
	input  logic                clk,
	input  logic                arst_n,
	ebcalu_req_if.sink          req,
	ebcalu_rsp_if.source        rsp
);
	import ebcalu_pkg::*;

	logic     vld_s1;
	alu_req_t req_s1;
	logic     vld_s2;
	alu_rsp_t rsp_s2;
	alu_rsp_t alu_rsp;
	logic     adv_s2;
	logic     adv_s1;

	// stage enables: each stage moves when its successor has room
	assign adv_s2    = ~vld_s2 | rsp.ready;
	assign adv_s1    = ~vld_s1 | adv_s2;
	assign req.ready = adv_s1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv_s1) begin
			vld_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && req.valid) begin
			req_s1 <= '{req_type: req.req_type, acc_in: req.acc_in,
				operand: req.operand, status_in: req.status_in};
		end
	end

	ebcalu_core u_core (
		.req (req_s1),
		.rsp (alu_rsp)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv_s2) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && vld_s1) begin
			rsp_s2 <= alu_rsp;
		end
	end

	assign rsp.valid      = vld_s2;
	assign rsp.result     = rsp_s2.result;
	assign rsp.status_out = rsp_s2.status_out;

endmodule

/* src/ebcalu_core.sv */
module ebcalu_core (
	input  ebcalu_pkg::alu_req_t req,
	output ebcalu_pkg::alu_rsp_t rsp
);
	import ebcalu_pkg::*;

	logic [7:0] a;
	logic [7:0] v;
	logic [7:0] sr;
	logic       cin;

	// binary adder / subtractor
	logic [8:0] bin_sum;
	logic [8:0] bin_dif;

	// decimal nibble arithmetic
	logic [4:0] dadd_lo;
	logic [4:0] dadd_lo_fix;
	logic [4:0] dadd_ha;
	logic [4:0] dadd_hi;
	logic [4:0] dadd_hi_fix;
	logic       dadd_c;
	logic [4:0] dsub_lo;
	logic [4:0] dsub_lo_fix;
	logic [4:0] dsub_ha;
	logic [4:0] dsub_hi;
	logic [4:0] dsub_hi_fix;
	logic       dsub_c;

	logic [7:0] r;
	logic [7:0] sr_n;

	assign a   = req.acc_in;
	assign v   = req.operand;
	assign sr  = req.status_in;
	assign cin = sr[FLAG_C];

	// binary paths; bin_dif[8] is the borrow out
	assign bin_sum = {1'b0, a} + {1'b0, v} + {8'd0, cin};
	assign bin_dif = {1'b0, a} - {1'b0, v} - {8'd0, ~cin};

	// decimal add: one correction per nibble
	always_comb begin
		dadd_lo = {1'b0, a[3:0]} + {1'b0, v[3:0]} + {4'd0, cin};
		if (dadd_lo > BCD_MAX) begin
			dadd_lo_fix = dadd_lo - BCD_TEN;
			dadd_ha     = {1'b0, a[7:4]} + 5'd1;
		end else begin
			dadd_lo_fix = dadd_lo;
			dadd_ha     = {1'b0, a[7:4]};
		end
		dadd_hi = dadd_ha + {1'b0, v[7:4]};
		if (dadd_hi > BCD_MAX) begin
			dadd_hi_fix = dadd_hi - BCD_TEN;
			dadd_c      = 1'b1;
		end else begin
			dadd_hi_fix = dadd_hi;
			dadd_c      = 1'b0;
		end
	end

	// decimal subtract: bit 4 of each nibble difference flags a borrow
	always_comb begin
		dsub_lo = {1'b0, a[3:0]} - {1'b0, v[3:0]} - {4'd0, ~cin};
		if (dsub_lo[4]) begin
			dsub_lo_fix = dsub_lo + BCD_TEN;
			dsub_ha     = {1'b0, a[7:4]} - 5'd1;
		end else begin
			dsub_lo_fix = dsub_lo;
			dsub_ha     = {1'b0, a[7:4]};
		end
		dsub_hi = dsub_ha - {1'b0, v[7:4]};
		if (dsub_hi[4]) begin
			dsub_hi_fix = dsub_hi + BCD_TEN;
			dsub_c      = 1'b0;
		end else begin
			dsub_hi_fix = dsub_hi;
			dsub_c      = 1'b1;
		end
	end

	// operation select and flag update
	always_comb begin
		r    = a;
		sr_n = sr;
		unique case (alu_op_t'(req.req_type))
			OP_ADC: begin
				if (sr[FLAG_D]) begin
					r            = {dadd_hi_fix[3:0], dadd_lo_fix[3:0]};
					sr_n[FLAG_C] = dadd_c;
				end else begin
					r            = bin_sum[7:0];
					sr_n[FLAG_C] = bin_sum[8];
					sr_n[FLAG_V] = ~(a[7] ^ v[7]) & (a[7] ^ bin_sum[7]);
				end
			end
			OP_SBC: begin
				if (sr[FLAG_D]) begin
					r            = {dsub_hi_fix[3:0], dsub_lo_fix[3:0]};
					sr_n[FLAG_C] = dsub_c;
				end else begin
					r            = bin_dif[7:0];
					sr_n[FLAG_C] = ~bin_dif[8];
					sr_n[FLAG_V] = (a[7] ^ bin_dif[7]) & (a[7] ^ v[7]);
				end
			end
			OP_AND: r = a & v;
			OP_ORA: r = a | v;
			OP_EOR: r = a ^ v;
			OP_ASL: begin
				r            = {v[6:0], 1'b0};
				sr_n[FLAG_C] = v[7];
			end
			OP_LSR: begin
				r            = {1'b0, v[7:1]};
				sr_n[FLAG_C] = v[0];
			end
			OP_ROL: begin
				r            = {v[6:0], cin};
				sr_n[FLAG_C] = v[7];
			end
			OP_ROR: begin
				r            = {cin, v[7:1]};
				sr_n[FLAG_C] = v[0];
			end
			OP_INC: r = v + 8'd1;
			OP_DEC: r = v - 8'd1;
			OP_BIT: begin
				r = a;
			end
			default: begin
				r = a;
			end
		endcase

		// Z/N from r; BIT: Z from a & v, N/V from v[7:6]; unused codes keep them
		if (alu_op_t'(req.req_type) == OP_BIT) begin
			sr_n[FLAG_Z] = ((a & v) == 8'd0);
			sr_n[FLAG_N] = v[7];
			sr_n[FLAG_V] = v[6];
		end else if (req.req_type <= OP_BIT) begin
			sr_n[FLAG_Z] = (r == 8'd0);
			sr_n[FLAG_N] = r[7];
		end
	end

	assign rsp.result     = r;
	assign rsp.status_out = sr_n;

endmodule
